// ===== rtl/fca_pkg.sv =====
// Package: entry kinds, status and opcode codes, table size and stream widths of the chain allocator.
package fca_pkg;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINK = 2'd2
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_BAD_COUNT = 3'd2;
    localparam logic [2:0] ST_BAD_BLOCK = 3'd3;
    localparam logic [2:0] ST_BROKEN    = 3'd4;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // table size, tied to the 5-bit block_id and 6-bit free_blocks fields
    localparam int NUM_BLOCKS = 32;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int CFG_W    = 8;

endpackage

// ===== rtl/fat_chain_allocator_top.sv =====
// Chain allocator: block table in a synchronous memory, create/delete/lookup sequencer.
//
//  channel | signals                      | direction | content
//  s_      | s_tvalid s_tready s_tdata    | in        | opcode, block_id, word_count
//  m_      | m_tvalid m_tready m_tdata    | out       | status, result_block, is_end,
//          |                              |           | is_free, word_address, free_blocks
//  cfg_    | cfg_valid cfg_ready cfg_data | in        | block_words
//
//  One item at a time.
//  Create scans the table one entry per cycle from index 0.
//  Delete walks the chain one entry per cycle (one read and one write per step).
//  The result waits in an output register; s_tready rises again once it is loaded.
//  Reset marks every entry free through per-entry valid bits, no sweep.
module fat_chain_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] opcode, [6:2] block_id, [22:7] word_count, [23] zero
    input  logic [fca_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [7:3] result_block, [8] is_end, [9] is_free,
    // [25:10] word_address, [31:26] free_blocks
    output logic [fca_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fca_pkg::CFG_W-1:0]      cfg_data
);

    localparam int NUM_BLOCKS = fca_pkg::NUM_BLOCKS;
    localparam int IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int FCW = $clog2(NUM_BLOCKS + 1);
    localparam int EW  = IW + 2;
    localparam int PW  = FCW + 8;
    localparam int CW  = (PW > 16) ? PW : 16;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_C_SCAN   = 8'b0000_0100,
        S_C_END    = 8'b0000_1000,
        S_C_ADDR   = 8'b0001_0000,
        S_D_CHECK  = 8'b0010_0000,
        S_L_CHECK  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    // table memory and its per-entry valid bits
    logic [EW-1:0]         mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [EW-1:0]         rd_data_reg;
    logic                  rd_ok_reg;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    state_t          state_reg, state_next;
    logic [1:0]      op_reg, op_next;
    logic [4:0]      id_reg, id_next;
    logic [15:0]     count_reg, count_next;
    logic [15:0]     rem_reg, rem_next;
    logic [IW-1:0]   scan_idx_reg, scan_idx_next;
    logic            chk_vld_reg, chk_vld_next;
    logic [IW-1:0]   chk_idx_reg, chk_idx_next;
    logic [IW-1:0]   prev_reg, prev_next;
    logic [IW-1:0]   head_reg, head_next;
    logic            have_prev_reg, have_prev_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [IW-1:0]   steps_reg, steps_next;
    logic            fwd_reg, fwd_next;
    logic [FCW-1:0]  free_count_reg, free_count_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic [4:0]      res_block_reg, res_block_next;
    logic            res_end_reg, res_end_next;
    logic            res_free_reg, res_free_next;
    logic [15:0]     res_addr_reg, res_addr_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [fca_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [7:0]      block_words_reg;
    logic [PW-1:0]   mul_reg;

    logic [7:0]          bw_eff;
    logic [FCW-1:0]      mul_a;
    fca_pkg::kind_t      rd_kind;
    logic [IW-1:0]       rd_link;
    logic                rd_free;
    logic                id_in_range;
    logic [IW-1:0]       id_idx;

    assign bw_eff      = (block_words_reg == 8'd0) ? 8'd1 : block_words_reg;
    assign rd_kind     = rd_ok_reg ? fca_pkg::kind_t'(rd_data_reg[EW-1:IW]) : fca_pkg::KIND_FREE;
    assign rd_link     = rd_ok_reg ? rd_data_reg[IW-1:0] : '0;
    assign rd_free     = (rd_kind == fca_pkg::KIND_FREE);
    assign id_in_range = (32'(id_reg) < NUM_BLOCKS);
    assign id_idx      = IW'(id_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        case (state_reg)
            S_IDLE:  mul_a = free_count_reg;
            S_C_END: mul_a = FCW'(head_reg);
            default: mul_a = FCW'(id_idx);
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        prev_next       = prev_reg;
        head_next       = head_reg;
        have_prev_next  = have_prev_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        fwd_next        = fwd_reg;
        free_count_next = free_count_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_end_next    = res_end_reg;
        res_free_next   = res_free_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_addr         = id_idx;
        wr_en           = 1'b0;
        wr_addr         = prev_reg;
        wr_data         = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[1:0];
                    id_next    = s_tdata[6:2];
                    count_next = s_tdata[22:7];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_status_next = fca_pkg::ST_OK;
                res_block_next  = '0;
                res_end_next    = 1'b0;
                res_free_next   = 1'b0;
                res_addr_next   = '0;
                state_next      = S_DONE;
                case (op_reg)
                    fca_pkg::OP_CREATE: begin
                        if (count_reg == 16'd0) begin
                            res_status_next = fca_pkg::ST_BAD_COUNT;
                        end else if (CW'(count_reg) > CW'(mul_reg)) begin
                            res_status_next = fca_pkg::ST_NO_SPACE;
                        end else begin
                            rem_next       = count_reg;
                            scan_idx_next  = '0;
                            chk_vld_next   = 1'b0;
                            have_prev_next = 1'b0;
                            state_next     = S_C_SCAN;
                        end
                    end
                    fca_pkg::OP_DELETE: begin
                        if (!id_in_range) begin
                            res_status_next = fca_pkg::ST_BAD_BLOCK;
                        end else begin
                            cur_next   = id_idx;
                            steps_next = '0;
                            fwd_next   = 1'b0;
                            state_next = S_D_CHECK;
                        end
                    end
                    fca_pkg::OP_LOOKUP: begin
                        if (!id_in_range) begin
                            res_status_next = fca_pkg::ST_BAD_BLOCK;
                        end else begin
                            state_next = S_L_CHECK;
                        end
                    end
                    default: ;
                endcase
            end
            S_C_SCAN: begin
                rd_addr       = scan_idx_reg;
                chk_vld_next  = 1'b1;
                chk_idx_next  = scan_idx_reg;
                scan_idx_next = (32'(scan_idx_reg) == NUM_BLOCKS - 1) ? scan_idx_reg
                                                                       : scan_idx_reg + 1'b1;
                if (chk_vld_reg && rd_free) begin
                    if (have_prev_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = prev_reg;
                        wr_data = {fca_pkg::KIND_LINK, chk_idx_reg};
                    end else begin
                        head_next = chk_idx_reg;
                    end
                    prev_next       = chk_idx_reg;
                    have_prev_next  = 1'b1;
                    free_count_next = free_count_reg - 1'b1;
                    if (rem_reg <= 16'(bw_eff)) begin
                        state_next = S_C_END;
                    end else begin
                        rem_next = rem_reg - 16'(bw_eff);
                    end
                end
            end
            S_C_END: begin
                wr_en      = 1'b1;
                wr_addr    = prev_reg;
                wr_data    = {fca_pkg::KIND_END, {IW{1'b0}}};
                state_next = S_C_ADDR;
            end
            S_C_ADDR: begin
                res_block_next = 5'(head_reg);
                res_addr_next  = mul_reg[15:0];
                state_next     = S_DONE;
            end
            S_D_CHECK: begin
                if (rd_free || fwd_reg) begin
                    res_status_next = fca_pkg::ST_BROKEN;
                    state_next      = S_DONE;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg;
                    wr_data         = {fca_pkg::KIND_FREE, {IW{1'b0}}};
                    free_count_next = free_count_reg + 1'b1;
                    if (rd_kind == fca_pkg::KIND_END) begin
                        state_next = S_DONE;
                    end else if (32'(steps_reg) == NUM_BLOCKS - 1) begin
                        res_status_next = fca_pkg::ST_BROKEN;
                        state_next      = S_DONE;
                    end else begin
                        rd_addr    = rd_link;
                        cur_next   = rd_link;
                        fwd_next   = (rd_link == cur_reg);
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_L_CHECK: begin
                res_block_next = (rd_kind == fca_pkg::KIND_LINK) ? 5'(rd_link) : 5'd0;
                res_end_next   = (rd_kind == fca_pkg::KIND_END);
                res_free_next  = rd_free;
                res_addr_next  = mul_reg[15:0];
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'(free_count_reg), res_addr_reg, res_free_reg,
                                     res_end_reg, res_block_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            free_count_reg  <= FCW'(NUM_BLOCKS);
            m_tvalid_reg    <= 1'b0;
            block_words_reg <= 8'd1;
            valid_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_valid) begin
                block_words_reg <= cfg_data;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        count_reg      <= count_next;
        rem_reg        <= rem_next;
        scan_idx_reg   <= scan_idx_next;
        chk_vld_reg    <= chk_vld_next;
        chk_idx_reg    <= chk_idx_next;
        prev_reg       <= prev_next;
        head_reg       <= head_next;
        have_prev_reg  <= have_prev_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        fwd_reg        <= fwd_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_end_reg    <= res_end_next;
        res_free_reg   <= res_free_next;
        res_addr_reg   <= res_addr_next;
        m_tdata_reg    <= m_tdata_next;
        mul_reg        <= PW'(mul_a * bw_eff);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= valid_reg[rd_addr];
    end

endmodule

// ===== test/tb.sv =====
// Testbench for fat_chain_allocator_top: directed table, then random create/delete/lookup traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS = fca_pkg::NUM_BLOCKS;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Laid out like m_tdata, status in the low bits.
    typedef struct packed {
        logic [5:0]  free_blocks;
        logic [15:0] word_address;
        logic        is_free;
        logic        is_end;
        logic [4:0]  result_block;
        logic [2:0]  status;
    } alloc_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  id;
        logic [15:0] cnt;
        bit          typed;
        alloc_res_t  want;
    } dir_row_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [fca_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [fca_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fca_pkg::CFG_W-1:0]      cfg_data  = '0;

    fat_chain_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // allocator shadow state
    fca_pkg::kind_t fat_kind [NUM_BLOCKS];
    logic [4:0]     fat_link [NUM_BLOCKS];
    int unsigned    free_left;
    logic [7:0]     words_per_block;

    alloc_res_t  pending_q[$];
    logic [4:0]  live_heads[$];
    dir_row_t    dir_rows[$];
    int          err_count = 0;
    int          result_no = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("fat_chain_allocator_top: mismatch");
        $finish;
    end

    function automatic int unsigned eff_words();
        return (words_per_block == 8'd0) ? 1 : int'(words_per_block);
    endfunction

    function automatic alloc_res_t alloc_op(logic [1:0] op, logic [4:0] id, logic [15:0] cnt);
        alloc_res_t     r;
        int unsigned    bw, need, got, prev, head, cur, steps;
        fca_pkg::kind_t k;
        logic [4:0]     nxt;
        bit             done;
        r = '0;
        bw = eff_words();
        case (op)
            fca_pkg::OP_CREATE: begin
                need = (int'(cnt) + bw - 1) / bw;
                if (cnt == 16'd0) begin
                    r.status = fca_pkg::ST_BAD_COUNT;
                end else if (need > free_left) begin
                    r.status = fca_pkg::ST_NO_SPACE;
                end else begin
                    got = 0;
                    prev = 0;
                    head = 0;
                    for (int i = 0; i < NUM_BLOCKS && got < need; i++) begin
                        if (fat_kind[i] == fca_pkg::KIND_FREE) begin
                            if (got == 0) begin
                                head = i;
                            end else begin
                                fat_kind[prev] = fca_pkg::KIND_LINK;
                                fat_link[prev] = i[4:0];
                            end
                            fat_kind[i] = fca_pkg::KIND_END;
                            fat_link[i] = '0;
                            prev = i;
                            got++;
                        end
                    end
                    free_left -= got;
                    r.status = fca_pkg::ST_OK;
                    r.result_block = head[4:0];
                    r.word_address = 16'(head * bw);
                end
            end
            fca_pkg::OP_DELETE: begin
                cur = id;
                done = 0;
                r.status = fca_pkg::ST_BROKEN;
                for (steps = 0; steps < NUM_BLOCKS && !done; steps++) begin
                    if (cur >= NUM_BLOCKS || fat_kind[cur] == fca_pkg::KIND_FREE) begin
                        done = 1;
                    end else begin
                        k = fat_kind[cur];
                        nxt = fat_link[cur];
                        fat_kind[cur] = fca_pkg::KIND_FREE;
                        fat_link[cur] = '0;
                        free_left++;
                        if (k == fca_pkg::KIND_END) begin
                            r.status = fca_pkg::ST_OK;
                            done = 1;
                        end
                        cur = nxt;
                    end
                end
            end
            fca_pkg::OP_LOOKUP: begin
                r.status = fca_pkg::ST_OK;
                r.result_block = (fat_kind[id] == fca_pkg::KIND_LINK) ? fat_link[id] : 5'd0;
                r.is_end = (fat_kind[id] == fca_pkg::KIND_END);
                r.is_free = (fat_kind[id] == fca_pkg::KIND_FREE);
                r.word_address = 16'(int'(id) * bw);
            end
            default: r.status = fca_pkg::ST_OK;
        endcase
        r.free_blocks = free_left[5:0];
        return r;
    endfunction

    function automatic alloc_res_t res(logic [2:0] st, logic [4:0] rb, logic e, logic f,
                                       logic [15:0] addr, logic [5:0] fb);
        alloc_res_t r;
        r.status = st;
        r.result_block = rb;
        r.is_end = e;
        r.is_free = f;
        r.word_address = addr;
        r.free_blocks = fb;
        return r;
    endfunction

    task automatic add_row(logic [1:0] op, logic [4:0] id, logic [15:0] cnt, bit typed,
                           alloc_res_t want);
        dir_row_t row;
        row.op = op;
        row.id = id;
        row.cnt = cnt;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_item(logic [1:0] op, logic [4:0] id, logic [15:0] cnt, bit typed,
                             alloc_res_t want);
        alloc_res_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, cnt, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = alloc_op(op, id, cnt);
        pending_q.push_back(typed ? want : r);
        if (op == fca_pkg::OP_CREATE && r.status == fca_pkg::ST_OK) begin
            live_heads.push_back(r.result_block);
        end
        @(negedge aclk);
    endtask

    task automatic write_block_words(logic [7:0] v);
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        words_per_block = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        alloc_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = alloc_res_t'(m_tdata);
            if (pending_q.size() == 0) begin
                $display("%0t result %0d: expected none, got %h", $time, result_no, m_tdata);
                err_count++;
            end else begin
                want = pending_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t result %0d: status expected %0d, got %0d",
                             $time, result_no, want.status, got.status);
                    err_count++;
                end
                if (got.result_block !== want.result_block) begin
                    $display("%0t result %0d: result_block expected %0d, got %0d",
                             $time, result_no, want.result_block, got.result_block);
                    err_count++;
                end
                if (got.is_end !== want.is_end) begin
                    $display("%0t result %0d: is_end expected %0d, got %0d",
                             $time, result_no, want.is_end, got.is_end);
                    err_count++;
                end
                if (got.is_free !== want.is_free) begin
                    $display("%0t result %0d: is_free expected %0d, got %0d",
                             $time, result_no, want.is_free, got.is_free);
                    err_count++;
                end
                if (got.word_address !== want.word_address) begin
                    $display("%0t result %0d: word_address expected %0d, got %0d",
                             $time, result_no, want.word_address, got.word_address);
                    err_count++;
                end
                if (got.free_blocks !== want.free_blocks) begin
                    $display("%0t result %0d: free_blocks expected %0d, got %0d",
                             $time, result_no, want.free_blocks, got.free_blocks);
                    err_count++;
                end
            end
            result_no++;
        end
    end

    initial begin
        logic [7:0]  cfg_set [6];
        logic [1:0]  op;
        logic [4:0]  id;
        logic [15:0] cnt;
        int unsigned pick, nb, idx;
        dir_row_t    row;

        for (int i = 0; i < NUM_BLOCKS; i++) begin
            fat_kind[i] = fca_pkg::KIND_FREE;
            fat_link[i] = '0;
        end
        free_left = NUM_BLOCKS;
        words_per_block = 8'd1;

        // block_words 1 after reset: word_address equals the block index
        add_row(fca_pkg::OP_LOOKUP, 5'd0, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b1, 16'd0, 6'd32));
        add_row(fca_pkg::OP_LOOKUP, 5'd31, 16'hFFFF, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b1, 16'd31, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd31, 16'd0, 1'b1,
                res(fca_pkg::ST_BAD_COUNT, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'hFFFF, 1'b1,
                res(fca_pkg::ST_NO_SPACE, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_DELETE, 5'd0, 16'd0, 1'b1,
                res(fca_pkg::ST_BROKEN, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(OP_NONE, 5'd31, 16'hFFFF, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd3, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd29));
        add_row(fca_pkg::OP_LOOKUP, 5'd0, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd1, 1'b0, 1'b0, 16'd0, 6'd29));
        add_row(fca_pkg::OP_LOOKUP, 5'd2, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b1, 1'b0, 16'd2, 6'd29));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd29, 1'b1,
                res(fca_pkg::ST_OK, 5'd3, 1'b0, 1'b0, 16'd3, 6'd0));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd1, 1'b1,
                res(fca_pkg::ST_NO_SPACE, 5'd0, 1'b0, 1'b0, 16'd0, 6'd0));
        add_row(fca_pkg::OP_LOOKUP, 5'd31, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b1, 1'b0, 16'd31, 6'd0));
        add_row(fca_pkg::OP_LOOKUP, 5'd17, 16'd0, 1'b0, '0);
        add_row(fca_pkg::OP_DELETE, 5'd1, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd2));
        add_row(fca_pkg::OP_DELETE, 5'd0, 16'd0, 1'b1,
                res(fca_pkg::ST_BROKEN, 5'd0, 1'b0, 1'b0, 16'd0, 6'd3));
        add_row(fca_pkg::OP_DELETE, 5'd3, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd32, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd0));
        add_row(fca_pkg::OP_LOOKUP, 5'd30, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd31, 1'b0, 1'b0, 16'd30, 6'd0));
        add_row(fca_pkg::OP_DELETE, 5'd0, 16'd0, 1'b1,
                res(fca_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd33, 1'b1,
                res(fca_pkg::ST_NO_SPACE, 5'd0, 1'b0, 1'b0, 16'd0, 6'd32));
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd5, 1'b0, '0);
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd2, 1'b0, '0);
        add_row(fca_pkg::OP_DELETE, 5'd0, 16'd0, 1'b0, '0);
        add_row(fca_pkg::OP_CREATE, 5'd0, 16'd8, 1'b0, '0);
        add_row(fca_pkg::OP_LOOKUP, 5'd4, 16'd0, 1'b0, '0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct = 23;
        snk_idle_pct = 69;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            push_item(row.op, row.id, row.cnt, row.typed, row.want);
        end
        s_tvalid <= 1'b0;

        cfg_set[0] = 8'd255;
        cfg_set[1] = 8'd0;
        cfg_set[2] = 8'd7;
        cfg_set[3] = 8'd1;
        cfg_set[4] = 8'($urandom_range(2, 254));
        cfg_set[5] = 8'd255;
        live_heads.delete();
        for (int p = 0; p < 6; p++) begin
            write_block_words(cfg_set[p]);
            case (p % 3)
                0: begin src_idle_pct = 23; snk_idle_pct = 69; end
                1: begin src_idle_pct = 69; snk_idle_pct = 23; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int n = 0; n < 155; n++) begin
                pick = $urandom_range(99);
                id = 5'($urandom);
                cnt = 16'($urandom);
                op = fca_pkg::OP_LOOKUP;
                if (pick < 35) begin
                    op = fca_pkg::OP_CREATE;
                    nb = ($urandom_range(9) == 0) ? $urandom_range(7, NUM_BLOCKS)
                                                  : $urandom_range(1, 6);
                    cnt = 16'($urandom_range(1, nb * eff_words()));
                end else if (pick < 65) begin
                    op = fca_pkg::OP_DELETE;
                    if (live_heads.size() != 0) begin
                        idx = $urandom_range(live_heads.size() - 1);
                        id = live_heads[idx];
                        live_heads.delete(idx);
                    end
                end else if (pick < 85) begin
                    op = fca_pkg::OP_LOOKUP;
                end else if (pick < 90) begin
                    op = OP_NONE;
                end else if (pick < 95) begin
                    op = fca_pkg::OP_CREATE;
                    if ($urandom_range(3) == 0) cnt = 16'd0;
                end else begin
                    op = fca_pkg::OP_DELETE;
                end
                push_item(op, id, cnt, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_count == 0) begin
            $display("fat_chain_allocator_top: match");
        end else begin
            $display("fat_chain_allocator_top: mismatch");
        end
        $finish;
    end
endmodule
